[src/pbsb_pkg.sv]
// Shared types, register indexes and default sizes of the sprite blit unit.
`timescale 1ns / 1ps
`default_nettype none
package pbsb_pkg;

  localparam int unsigned DefScreenPages    = 8;
  localparam int unsigned DefScreenColumns  = 128;
  localparam int unsigned DefMaxSpriteWidth = 128;

  localparam int unsigned PageBits = 8;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 10;

  localparam logic [CfgIndexW-1:0] REG_PLACE_MODE    = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_ANCHOR_COLUMN = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_ANCHOR_ROW    = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_SPRITE_WIDTH  = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_SPRITE_PAGES  = 3'd4;

  typedef struct packed {
    logic       place_mode;
    logic [7:0] anchor_column;
    logic [9:0] anchor_row;
    logic [7:0] sprite_width;
    logic [5:0] sprite_pages;
  } cfg_t;

  typedef struct packed {
    logic       main_ok;
    logic       spill_ok;
    logic [2:0] main_page;
    logic [2:0] spill_page;
    logic [6:0] column;
    logic [7:0] main_value;
    logic [7:0] spill_value;
  } plan_t;

endpackage
`default_nettype wire

[src/pbsb_line_mem.sv]
// Line buffer memory holding the previous sprite page's byte for each column.
`timescale 1ns / 1ps
`default_nettype none
module pbsb_line_mem #(
  parameter int unsigned DEPTH = pbsb_pkg::DefMaxSpriteWidth,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

endmodule
`default_nettype wire

[src/pbsb_count.sv]
// Column and page position counters of the incoming sprite stream.
`timescale 1ns / 1ps
`default_nettype none
module pbsb_count (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       first,
  input  wire logic [7:0] sprite_width,
  input  wire logic [5:0] sprite_pages,
  output logic      [7:0] column,
  output logic      [5:0] page
);

  logic [7:0] column_count;
  logic [5:0] page_count;
  logic [7:0] column_inc;
  logic [5:0] page_inc;

  assign column     = first ? 8'd0 : column_count;
  assign page       = first ? 6'd0 : page_count;
  assign column_inc = column + 8'd1;
  assign page_inc   = page + 6'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      page_count   <= '0;
    end else if (accept) begin
      if (column_inc >= sprite_width) begin
        column_count <= '0;
        page_count   <= (page_inc >= sprite_pages) ? 6'd0 : page_inc;
      end else begin
        column_count <= column_inc;
        page_count   <= page;
      end
    end
  end

endmodule
`default_nettype wire

[src/pbsb_place.sv]
// Placement, bit merge and screen clipping of one sprite byte.
`timescale 1ns / 1ps
`default_nettype none
module pbsb_place #(
  parameter int unsigned SCREEN_PAGES   = pbsb_pkg::DefScreenPages,
  parameter int unsigned SCREEN_COLUMNS = pbsb_pkg::DefScreenColumns
) (
  input  wire pbsb_pkg::cfg_t  cfg,
  input  wire logic [7:0]      cur,
  input  wire logic [7:0]      above,
  input  wire logic [7:0]      column,
  input  wire logic [5:0]      page,
  output pbsb_pkg::plan_t      plan
);

  logic [2:0]  off;
  logic [11:0] page_pos;
  logic [11:0] spill_pos;
  logic [10:0] col_pos;
  logic [15:0] merged;
  logic [15:0] spilled;
  logic        col_ok;
  logic        last_page;

  assign off = cfg.anchor_row[2:0];

  always_comb begin
    if (cfg.place_mode) begin
      page_pos = {5'd0, cfg.anchor_row[9:3]} - {6'd0, cfg.sprite_pages} + {6'd0, page};
      col_pos  = {3'd0, cfg.anchor_column} - {3'd0, cfg.sprite_width} + {3'd0, column};
    end else begin
      page_pos = {2'd0, cfg.anchor_row} + {6'd0, page};
      col_pos  = {3'd0, cfg.anchor_column} + {3'd0, column};
    end
  end

  assign spill_pos = page_pos + 12'd1;
  assign merged    = {cur, above} << off;
  assign spilled   = {8'd0, cur} << off;
  assign col_ok    = !col_pos[10] && (col_pos[9:0] < 10'(SCREEN_COLUMNS));
  assign last_page = ({1'b0, page} + 7'd1) == {1'b0, cfg.sprite_pages};

  always_comb begin
    plan.main_ok     = col_ok && !page_pos[11] && (page_pos[10:0] < 11'(SCREEN_PAGES));
    plan.spill_ok    = cfg.place_mode && last_page && col_ok && !spill_pos[11]
                       && (spill_pos[10:0] < 11'(SCREEN_PAGES));
    plan.main_page   = page_pos[2:0];
    plan.spill_page  = spill_pos[2:0];
    plan.column      = col_pos[6:0];
    plan.main_value  = cfg.place_mode ? merged[15:8] : cur;
    plan.spill_value = spilled[15:8];
  end

endmodule
`default_nettype wire

[src/page_buffer_sprite_blit_unit.sv]
// Top level of the page buffer sprite blit unit: registers, pipeline and output stage.
`timescale 1ns / 1ps
`default_nettype none
// The unit takes one sprite byte per clock cycle while the output is not stalled and
// returns the clipped frame-buffer writes it causes through the placement stage register
// and a registered output stage. An item whose two writes (main page and spill page on
// the last sprite page in mode 1) both fall on the screen holds the input until its
// second write is sent; every other item flows at that rate. The line buffer is a
// single-port memory with a registered read, read and written at the column of each
// incoming byte. Its contents are undefined after reset and it has no clearing pass:
// start each image with first_of_image set.
module page_buffer_sprite_blit_unit #(
  parameter int unsigned SCREEN_PAGES     = pbsb_pkg::DefScreenPages,
  parameter int unsigned SCREEN_COLUMNS   = pbsb_pkg::DefScreenColumns,
  parameter int unsigned MAX_SPRITE_WIDTH = pbsb_pkg::DefMaxSpriteWidth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [pbsb_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [pbsb_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    pixel_byte,
  input  wire logic                          first_of_image,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [2:0]                    write_page,
  output logic      [6:0]                    write_column,
  output logic      [7:0]                    write_value,
  output logic                               last_write
);

  localparam int unsigned AW = $clog2(MAX_SPRITE_WIDTH);

  pbsb_pkg::cfg_t  cfg;
  pbsb_pkg::plan_t plan;

  logic       accept;
  logic [7:0] column;
  logic [5:0] page;
  logic       in_store;
  logic [7:0] rdata;

  logic       s1_valid;
  logic       s1_phase;
  logic [7:0] s1_cur;
  logic [7:0] s1_column;
  logic [5:0] s1_page;
  logic       s1_above_ok;
  logic [7:0] above;

  logic       first_sel;
  logic       emit_valid;
  logic       emit_last;
  logic       emit_fire;
  logic       out_free;
  logic       s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.place_mode    <= 1'b0;
      cfg.anchor_column <= '0;
      cfg.anchor_row    <= '0;
      cfg.sprite_width  <= 8'd1;
      cfg.sprite_pages  <= 6'd1;
    end else if (cfg_wen) begin
      case (cfg_index)
        pbsb_pkg::REG_PLACE_MODE:    cfg.place_mode    <= cfg_data[0];
        pbsb_pkg::REG_ANCHOR_COLUMN: cfg.anchor_column <= cfg_data[7:0];
        pbsb_pkg::REG_ANCHOR_ROW:    cfg.anchor_row    <= cfg_data[9:0];
        pbsb_pkg::REG_SPRITE_WIDTH:  cfg.sprite_width  <= cfg_data[7:0];
        pbsb_pkg::REG_SPRITE_PAGES:  cfg.sprite_pages  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && in_ready;
  assign in_store = {1'b0, column} < 9'(MAX_SPRITE_WIDTH);

  pbsb_count u_count (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .first        (first_of_image),
    .sprite_width (cfg.sprite_width),
    .sprite_pages (cfg.sprite_pages),
    .column       (column),
    .page         (page)
  );

  pbsb_line_mem #(
    .DEPTH (MAX_SPRITE_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk   (clk),
    .rd_en (accept),
    .wr_en (accept && in_store),
    .addr  (column[AW-1:0]),
    .wdata (pixel_byte),
    .rdata (rdata)
  );

  assign above = s1_above_ok ? rdata : 8'd0;

  pbsb_place #(
    .SCREEN_PAGES   (SCREEN_PAGES),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_place (
    .cfg    (cfg),
    .cur    (s1_cur),
    .above  (above),
    .column (s1_column),
    .page   (s1_page),
    .plan   (plan)
  );

  assign first_sel  = !s1_phase && plan.main_ok;
  assign emit_valid = s1_valid && (plan.main_ok || plan.spill_ok);
  assign emit_last  = !first_sel || !plan.spill_ok;
  assign out_free   = !out_valid || out_ready;
  assign emit_fire  = emit_valid && out_free;
  assign s1_done    = s1_valid && (!emit_valid || (emit_fire && emit_last));
  assign in_ready   = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done) begin
        s1_phase <= 1'b0;
      end else if (emit_fire && !emit_last) begin
        s1_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur      <= pixel_byte;
      s1_column   <= column;
      s1_page     <= page;
      s1_above_ok <= (page != 6'd0) && in_store;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      write_page   <= first_sel ? plan.main_page : plan.spill_page;
      write_column <= plan.column;
      write_value  <= first_sel ? plan.main_value : plan.spill_value;
      last_write   <= emit_last;
    end
  end

  a_phase_has_spill : assert property (@(posedge clk) disable iff (rst)
    s1_phase |-> (s1_valid && plan.spill_ok))
    else $error("second write pending without a spill write");

  a_split_sets_phase : assert property (@(posedge clk) disable iff (rst)
    (emit_fire && !emit_last) |=> (s1_phase && s1_valid))
    else $error("first of two writes sent but the stage lost its item");

  a_accept_loads_stage : assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transfer did not reach the placement stage");

  a_held_output : assert property (@(posedge clk) disable iff (rst)
    (s1_phase && !out_free) |=> s1_phase)
    else $error("spill write dropped while the output was stalled");

endmodule
`default_nettype wire
